### src/pdsv_pkg.sv
// shared types and constants of the stepped-valve pd controller
package pdsv_pkg;

  // fixed design constants
  localparam logic        COOLING        = 1'b0;
  localparam logic [9:0]  POWER_FLOOR    = 10'd0;
  localparam logic [9:0]  POWER_CAP      = 10'd999;
  localparam logic [9:0]  VALVE_DEADBAND = 10'd10;

  // proportional term: saturation threshold on |err*gain| and reciprocal of 10
  localparam logic [29:0] PSAT_LIMIT = 30'd327680;
  localparam int unsigned RecipShift = 22;
  localparam logic [18:0] RECIP10    = 19'd419431;

  // derivative clamp, +-32000.0 in q31.16
  localparam logic signed [47:0] DLIM_POS = 48'sd2097152000;
  localparam logic signed [47:0] DLIM_NEG = -48'sd2097152000;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_SETPOINT  = 3'd0,
    CFG_PROP_GAIN = 3'd1,
    CFG_DIFF_GAIN = 3'd2,
    CFG_STEP_SLOW = 3'd3,
    CFG_STEP_FAST = 3'd4,
    CFG_ZERO_BAND = 3'd5,
    CFG_FAST_BAND = 3'd6,
    CFG_POWER_TOP = 3'd7
  } cfg_idx_e;

  // loop modes
  typedef enum logic [1:0] {
    MODE_OFF       = 2'd0,
    MODE_AUTO      = 2'd1,
    MODE_BREAKDOWN = 2'd2,
    MODE_WARNING   = 2'd3
  } loop_mode_e;

  // registers used by the power stage
  typedef struct packed {
    logic [9:0]  step_slow;
    logic [9:0]  step_fast;
    logic [15:0] zero_band;
    logic [15:0] fast_band;
    logic [9:0]  power_top;
  } act_cfg_t;

  // item entering the power stage
  typedef struct packed {
    logic        func;
    logic        manual;
    logic        run;
    logic [9:0]  valve;
    logic [9:0]  load;
    logic [16:0] demand;
  } act_item_t;

endpackage

### src/pdsv_actuator.sv
// power stage: step accumulator, power output and valve drive flags
module pdsv_actuator import pdsv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  act_item_t  item_i,
  input  act_cfg_t   cfg_i,
  output logic [9:0] power_o,
  output logic       open_o,
  output logic       close_o
);

  logic signed [11:0] acc_q, acc_d;
  logic [9:0]         power_q, power_d;
  logic               open_q, open_d;
  logic               close_q, close_d;

  // step, carry whole units into power, clamp, compare with valve
  always_comb begin
    logic signed [16:0] dem;
    logic [16:0]        mag;
    logic               step_on;
    logic               pos;
    logic [9:0]         step;
    logic signed [11:0] acc_sum;
    logic signed [2:0]  delta;
    logic signed [11:0] acc_rem;
    logic signed [11:0] pw_t;
    logic [9:0]         pw_new;
    logic [9:0]         pw_eff;
    logic signed [10:0] dv;
    logic signed [10:0] db;

    dem     = $signed(item_i.demand);
    mag     = dem[16] ? 17'(-dem) : 17'(dem);
    step_on = mag >= {1'b0, cfg_i.zero_band};
    step    = (mag < {1'b0, cfg_i.fast_band}) ? cfg_i.step_slow : cfg_i.step_fast;
    pos     = !dem[16] && (dem != 17'sd0);

    if (!step_on) begin
      acc_sum = acc_q;
    end else if (pos) begin
      acc_sum = acc_q + $signed({2'b00, step});
    end else begin
      acc_sum = acc_q - $signed({2'b00, step});
    end

    // truncating divide by 1000, accumulator stays below 1000 in magnitude
    if (acc_sum >= 12'sd2000) begin
      delta   = 3'sd2;
      acc_rem = acc_sum - 12'sd2000;
    end else if (acc_sum >= 12'sd1000) begin
      delta   = 3'sd1;
      acc_rem = acc_sum - 12'sd1000;
    end else if (acc_sum <= -12'sd2000) begin
      delta   = -3'sd2;
      acc_rem = acc_sum + 12'sd2000;
    end else if (acc_sum <= -12'sd1000) begin
      delta   = -3'sd1;
      acc_rem = acc_sum + 12'sd1000;
    end else begin
      delta   = 3'sd0;
      acc_rem = acc_sum;
    end

    // power clamp: fixed cap, floor, then configured max
    pw_t = $signed({2'b00, power_q}) + $signed({{9{delta[2]}}, delta});
    if (pw_t > $signed({2'b00, POWER_CAP})) pw_t = $signed({2'b00, POWER_CAP});
    if (pw_t < $signed({2'b00, POWER_FLOOR})) pw_t = $signed({2'b00, POWER_FLOOR});
    if (pw_t > $signed({2'b00, cfg_i.power_top})) pw_t = $signed({2'b00, cfg_i.power_top});
    pw_new = pw_t[9:0];

    // valve compare with deadband
    pw_eff = item_i.run ? pw_new : power_q;
    dv     = $signed({1'b0, pw_eff}) - $signed({1'b0, item_i.valve});
    db     = $signed({1'b0, VALVE_DEADBAND});

    acc_d   = acc_q;
    power_d = power_q;
    open_d  = open_q;
    close_d = close_q;
    if (item_i.func) begin
      power_d = item_i.load;
    end else if (!item_i.manual) begin
      if (item_i.run) begin
        acc_d   = acc_rem;
        power_d = pw_new;
      end
      open_d  = (dv > 11'sd0) && (dv >= db);
      close_d = (dv < 11'sd0) && ((-dv) >= db);
    end
  end

  // state moves only when an item leaves for the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      power_q <= '0;
      open_q  <= 1'b0;
      close_q <= 1'b0;
    end else if (en_i) begin
      acc_q   <= acc_d;
      power_q <= power_d;
      open_q  <= open_d;
      close_q <= close_d;
    end
  end

  assign power_o = power_q;
  assign open_o  = open_q;
  assign close_o = close_q;

endmodule

### src/pd_stepped_valve_controller.sv
// top level of the stepped-valve pd controller
//
//  port group      dir  tdata / tuser contents (low bit first)
//  s_axis_*        in   tdata: measured[15:0] valve_position[25:16] loop_mode[27:26]
//                       manual[28] load_value[38:29]; tuser: func
//  m_axis_*        out  tdata: power_level[9:0] valve_open[10] valve_close[11]
//                       demand[28:12]
//  cfg_*           in   write enable, register index, 16-bit write data
//
//  one item per clock sustained while the result side accepts; a taken item
//  passes the input register, product register, filter register, demand
//  register and result register; the derivative filter and the power
//  accumulator each close their loop inside one stage
//  reset clears all controller state and loads the register defaults
//  a stalled result holds the pipe only as far back as the first empty stage
module pd_stepped_valve_controller import pdsv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // measured, valve_position, loop_mode, manual, load_value
  input  logic        s_axis_tuser,   // func
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // power_level, valve_open, valve_close, demand
  // configuration writes
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  // configuration registers
  logic signed [15:0] setpoint_q;
  logic [13:0]        prop_gain_q;
  logic [13:0]        diff_gain_q;
  act_cfg_t           act_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q          <= 16'sd220;
      prop_gain_q         <= 14'd100;
      diff_gain_q         <= 14'd500;
      act_cfg_q.step_slow <= 10'd0;
      act_cfg_q.step_fast <= 10'd0;
      act_cfg_q.zero_band <= 16'd0;
      act_cfg_q.fast_band <= 16'd0;
      act_cfg_q.power_top <= 10'd999;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SETPOINT:  setpoint_q          <= $signed(cfg_wdata_i);
        CFG_PROP_GAIN: prop_gain_q         <= cfg_wdata_i[13:0];
        CFG_DIFF_GAIN: diff_gain_q         <= cfg_wdata_i[13:0];
        CFG_STEP_SLOW: act_cfg_q.step_slow <= cfg_wdata_i[9:0];
        CFG_STEP_FAST: act_cfg_q.step_fast <= cfg_wdata_i[9:0];
        CFG_ZERO_BAND: act_cfg_q.zero_band <= cfg_wdata_i;
        CFG_FAST_BAND: act_cfg_q.fast_band <= cfg_wdata_i;
        CFG_POWER_TOP: act_cfg_q.power_top <= cfg_wdata_i[9:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control
  logic v0_q, v1_q, v2_q, v3_q, vo_q;
  logic free_o, free3, free2, free1, free0;
  logic mv0, mv1, mv2, mv3, take_in;

  assign free_o  = !vo_q || m_axis_tready;
  assign free3   = !v3_q || free_o;
  assign free2   = !v2_q || free3;
  assign free1   = !v1_q || free2;
  assign free0   = !v0_q || free1;
  assign mv3     = v3_q && free_o;
  assign mv2     = v2_q && free3;
  assign mv1     = v1_q && free2;
  assign mv0     = v0_q && free1;
  assign take_in = s_axis_tvalid && free0;

  assign s_axis_tready = free0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      v0_q <= take_in || (v0_q && !mv0);
      v1_q <= mv0 || (v1_q && !mv1);
      v2_q <= mv1 || (v2_q && !mv2);
      v3_q <= mv2 || (v3_q && !mv3);
      vo_q <= mv3 || (vo_q && !m_axis_tready);
    end
  end

  // input register
  logic               func0_q, manual0_q;
  logic signed [15:0] meas0_q;
  logic [9:0]         valve0_q, load0_q;
  logic [1:0]         mode0_q;

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      meas0_q   <= $signed(s_axis_tdata[15:0]);
      valve0_q  <= s_axis_tdata[25:16];
      mode0_q   <= s_axis_tdata[27:26];
      manual0_q <= s_axis_tdata[28];
      load0_q   <= s_axis_tdata[38:29];
      func0_q   <= s_axis_tuser;
    end
  end

  // error, proportional product and derivative product
  logic signed [15:0] err_raw, err;
  logic signed [15:0] last_err_q;
  logic signed [16:0] diff;
  logic signed [30:0] prod_p, prod_x;
  logic               run0;

  assign err_raw = setpoint_q - meas0_q;
  assign err     = COOLING ? -err_raw : err_raw;
  assign run0    = !func0_q && !manual0_q &&
                   ((loop_mode_e'(mode0_q) == MODE_AUTO) ||
                    (loop_mode_e'(mode0_q) == MODE_WARNING));
  assign diff    = {err[15], err} - {last_err_q[15], last_err_q};
  assign prod_p  = $signed({{15{err[15]}}, err}) * $signed({17'd0, prop_gain_q});
  assign prod_x  = $signed({{14{diff[16]}}, diff}) * $signed({17'd0, diff_gain_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_err_q <= '0;
    end else if (mv0 && run0) begin
      last_err_q <= err;
    end
  end

  logic signed [30:0] prod_p1_q, prod_x1_q;
  logic               run1_q, func1_q, manual1_q;
  logic [9:0]         valve1_q, load1_q;

  always_ff @(posedge clk_i) begin
    if (mv0) begin
      prod_p1_q <= prod_p;
      prod_x1_q <= prod_x;
      run1_q    <= run0;
      func1_q   <= func0_q;
      manual1_q <= manual0_q;
      valve1_q  <= valve0_q;
      load1_q   <= load0_q;
    end
  end

  // proportional divide by ten with saturation
  logic               p_neg, p_big;
  logic [29:0]        p_mag;
  logic [37:0]        p_recip;
  logic [15:0]        p_quo;
  logic signed [15:0] p_term;

  assign p_neg   = prod_p1_q[30];
  assign p_mag   = p_neg ? 30'(-prod_p1_q) : prod_p1_q[29:0];
  assign p_big   = p_mag >= PSAT_LIMIT;
  assign p_recip = {19'd0, p_mag[18:0]} * {19'd0, RECIP10};
  assign p_quo   = p_recip[RecipShift+15:RecipShift];
  assign p_term  = p_big ? (p_neg ? -16'sd32768 : 16'sd32767)
                         : (p_neg ? -$signed(p_quo) : $signed(p_quo));

  // derivative low-pass: f + floor((x*65536 - f)/64)
  logic signed [47:0] filt_q, filt_new;
  logic signed [48:0] filt_gap;

  assign filt_gap = $signed({{2{prod_x1_q[30]}}, prod_x1_q, 16'd0}) -
                    $signed({filt_q[47], filt_q});
  assign filt_new = filt_q + $signed({{5{filt_gap[48]}}, filt_gap[48:6]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_q <= '0;
    end else if (mv1 && run1_q) begin
      filt_q <= filt_new;
    end
  end

  logic signed [15:0] p_term2_q;
  logic signed [47:0] filt2_q;
  logic               run2_q, func2_q, manual2_q;
  logic [9:0]         valve2_q, load2_q;

  always_ff @(posedge clk_i) begin
    if (mv1) begin
      p_term2_q <= p_term;
      filt2_q   <= filt_new;
      run2_q    <= run1_q;
      func2_q   <= func1_q;
      manual2_q <= manual1_q;
      valve2_q  <= valve1_q;
      load2_q   <= load1_q;
    end
  end

  // derivative term: clamp, times ten, truncate q16, saturate, add p
  logic signed [47:0] d_clamp;
  logic signed [32:0] d_c33;
  logic signed [35:0] d_c10, d_rnd;
  logic signed [19:0] d_raw;
  logic signed [15:0] d_term;
  logic signed [16:0] demand;

  always_comb begin
    if (filt2_q > DLIM_POS) begin
      d_clamp = DLIM_POS;
    end else if (filt2_q < DLIM_NEG) begin
      d_clamp = DLIM_NEG;
    end else begin
      d_clamp = filt2_q;
    end
  end

  assign d_c33  = d_clamp[32:0];
  assign d_c10  = $signed({d_c33, 3'b000}) + $signed({d_c33[32], d_c33, 1'b0});
  assign d_rnd  = d_c10 + (d_c10[35] ? 36'sd65535 : 36'sd0);
  assign d_raw  = d_rnd[35:16];
  assign d_term = (d_raw > 20'sd32767)  ? 16'sd32767 :
                  (d_raw < -20'sd32768) ? -16'sd32768 : d_raw[15:0];
  assign demand = run2_q ? ({p_term2_q[15], p_term2_q} + {d_term[15], d_term}) : 17'sd0;

  act_item_t item3_q;

  always_ff @(posedge clk_i) begin
    if (mv2) begin
      item3_q.func   <= func2_q;
      item3_q.manual <= manual2_q;
      item3_q.run    <= run2_q;
      item3_q.valve  <= valve2_q;
      item3_q.load   <= load2_q;
      item3_q.demand <= demand;
    end
  end

  // power stage, its state doubles as the result register
  logic [9:0]  power_level;
  logic        valve_open, valve_close;
  logic [16:0] demand_o_q;

  pdsv_actuator u_actuator (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (mv3),
    .item_i  (item3_q),
    .cfg_i   (act_cfg_q),
    .power_o (power_level),
    .open_o  (valve_open),
    .close_o (valve_close)
  );

  always_ff @(posedge clk_i) begin
    if (mv3) begin
      demand_o_q <= item3_q.demand;
    end
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = {3'b000, demand_o_q, valve_close, valve_open, power_level};

  // checks
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (vo_q && !m_axis_tready))
    else $error("input blocked while the result side can move");

  a_power_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !mv3 |=> $stable(m_axis_tdata[11:0]))
    else $error("power stage state changed without an item leaving");

  a_filter_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mv1 && run1_q) |=> $stable(filt_q))
    else $error("derivative filter changed without a running item");

  a_drive_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(valve_open && valve_close))
    else $error("valve driven open and closed together");

endmodule
